FILE: src/gtu_pkg.sv
// Shared types, constants and calendar tables for the GPS to UTC calendar converter.
package gtu_pkg;

  typedef logic [11:0] week_t;
  typedef logic [19:0] tow_t;
  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [5:0]  leap_t;
  typedef logic [16:0] sod_t;
  typedef logic [14:0] dcount_t;
  typedef logic [8:0]  doy_t;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
  } date_t;

  localparam leap_t   LEAP_OFS_RESET = 6'd18;
  localparam sod_t    SEC_PER_DAY    = 17'd86400;
  localparam tow_t    SEC_PER_WEEK   = 20'd604800;
  localparam dcount_t EPOCH_SHIFT    = 15'd5;
  localparam year_t   EPOCH_YEAR     = 12'd1980;
  localparam logic [10:0] CYCLE_DAYS = 11'd1461;
  localparam logic [8:0]  DAYS_STD   = 9'd365;

  // floor(x / 1461) = (x * CYC_RECIP) >> CYC_SHIFT for x below 2^15
  localparam logic [14:0] CYC_RECIP  = 15'd22967;
  localparam int          CYC_SHIFT  = 25;
  // floor(x / 225) for x below 5400
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  localparam int          HOUR_SHIFT = 20;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  // floor(x / 15) for x below 900
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  localparam int          MIN_SHIFT  = 14;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  localparam month_t JANUARY  = 4'd1;
  localparam month_t DECEMBER = 4'd12;

  function automatic doy_t cum_days(input logic leap, input month_t idx);
    doy_t d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d + {8'd0, (leap && (idx >= 4'd2))};
  endfunction

  function automatic day_t month_len(input logic leap, input month_t month);
    month_t m;
    doy_t   diff;
    m    = ((month >= JANUARY) && (month <= DECEMBER)) ? month : JANUARY;
    diff = cum_days(leap, m) - cum_days(leap, m - 4'd1);
    return diff[4:0];
  endfunction

endpackage

FILE: src/gtu_if.sv
// Valid/ready channel interfaces for timestamps in and calendar results out.
interface gtu_in_if import gtu_pkg::*; ();
  logic  valid;
  logic  ready;
  week_t week_num;
  tow_t  time_of_week;

  modport source(output valid, week_num, time_of_week, input ready);
  modport sink(input valid, week_num, time_of_week, output ready);
endinterface

interface gtu_out_if import gtu_pkg::*; ();
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  hour_t   hour;
  minute_t minute;
  second_t second;
  logic    input_invalid;

  modport source(output valid, year, month, day, hour, minute, second, input_invalid,
                 input ready);
  modport sink(input valid, year, month, day, hour, minute, second, input_invalid,
               output ready);
endinterface

FILE: src/gtu_date.sv
// Calendar date pipeline: day count to year, month and day, with leap second borrow.
module gtu_date import gtu_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  dcount_t t_i,
  input  logic    borrow_i,
  output date_t   date_o
);

  // stage 2: reciprocal product for the 1461-day cycle
  logic [29:0] cprod_r;
  dcount_t     t2_r;

  // stage 3: year and day of year
  logic [4:0]  cyc;
  logic [10:0] rem_c;
  logic [1:0]  yic;
  logic [10:0] doy_w;
  doy_t        doy_c;
  year_t       year_c;
  year_t       year3_r;
  doy_t        doy3_r;
  logic        leap3_r;
  logic        brw3_r;

  // stage 4: month and day
  month_t      month_c;
  doy_t        day_w;
  year_t       year4_r;
  month_t      month4_r;
  day_t        day4_r;
  logic        brw4_r;

  // stage 5: borrow into previous day
  date_t       date_nxt;
  date_t       date_r;
  day_t        day_m1;

  always_ff @(posedge clk) begin
    if (en) begin
      cprod_r <= 30'(t_i) * 30'(CYC_RECIP);
      t2_r    <= t_i;
    end
  end

  always_comb begin
    cyc   = cprod_r[CYC_SHIFT+4:CYC_SHIFT];
    rem_c = 11'(t2_r - 15'(cyc) * 15'(CYCLE_DAYS));
    if (rem_c <= 11'd365) begin
      yic = 2'd0;
    end else if (rem_c <= 11'd730) begin
      yic = 2'd1;
    end else if (rem_c <= 11'd1095) begin
      yic = 2'd2;
    end else begin
      yic = 2'd3;
    end
    if (yic == 2'd0) begin
      doy_w = rem_c + 11'd1;
    end else begin
      doy_w = rem_c - 11'(yic) * 11'(DAYS_STD);
    end
    doy_c  = doy_w[8:0];
    year_c = EPOCH_YEAR + {5'd0, cyc, 2'b00} + {10'd0, yic};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year3_r <= year_c;
      doy3_r  <= doy_c;
      leap3_r <= (yic == 2'd0);
      brw3_r  <= borrow_i;
    end
  end

  always_comb begin
    month_c = JANUARY;
    for (int i = 1; i < 12; i++) begin
      if (doy3_r > cum_days(leap3_r, 4'(i))) begin
        month_c = 4'(i + 1);
      end
    end
    day_w = doy3_r - cum_days(leap3_r, month_c - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year4_r  <= year3_r;
      month4_r <= month_c;
      day4_r   <= day_w[4:0];
      brw4_r   <= brw3_r;
    end
  end

  always_comb begin
    date_nxt.year  = year4_r;
    date_nxt.month = month4_r;
    date_nxt.day   = day4_r;
    day_m1         = day4_r - 5'd1;
    if (brw4_r) begin
      date_nxt.day = day_m1;
      if (day_m1 == 5'd0) begin
        if (month4_r == JANUARY) begin
          date_nxt.month = DECEMBER;
          date_nxt.year  = year4_r - 12'd1;
        end else begin
          date_nxt.month = month4_r - 4'd1;
        end
        date_nxt.day = month_len(date_nxt.year[1:0] == 2'b00, date_nxt.month);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      date_r <= date_nxt;
    end
  end

  assign date_o = date_r;

endmodule

FILE: src/gps_time_to_utc_calendar_unit.sv
// Top level: GPS week and time of week to UTC calendar date and time of day.
//
//   port      dir   handshake      carries
//   in_ch     in    valid/ready    week_num, time_of_week
//   out_ch    out   valid/ready    year, month, day, hour, minute, second, input_invalid
//   cfg_*     in    write enable   leap offset
//
// Six register stages; one item per cycle. An item accepted from in_ch passes
// through stages 1 to 5 and the output stage in order before it is shown on out_ch.
// All stages advance together; a stalled output holds the whole pipeline
// and in_ch.ready falls, so nothing is dropped or repeated.
// Reset clears the stage valid bits and loads the leap offset with 18.
module gps_time_to_utc_calendar_unit import gtu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  leap_t     cfg_wr_data,
  gtu_in_if.sink    in_ch,
  gtu_out_if.source out_ch
);

  logic en;

  leap_t leap_r;

  // stage 1
  logic [2:0] dow_c;
  tow_t       day_base;
  logic       v1_r, inv1_r;
  sod_t       sod1_r;
  dcount_t    t1_r;

  // stage 2
  logic       brw_c;
  logic       v2_r, inv2_r, brw2_r;
  sod_t       sod2_r;

  // stage 3
  logic       v3_r, inv3_r;
  logic [25:0] hprod3_r;
  sod_t       sod3_r;

  // stage 4
  hour_t      hour_c;
  logic       v4_r, inv4_r;
  hour_t      hour4_r;
  logic [11:0] rem4_r;

  // stage 5
  logic       v5_r, inv5_r;
  hour_t      hour5_r;
  logic [11:0] rem5_r;
  logic [20:0] mprod5_r;

  // output stage
  minute_t    minute_c;
  date_t      date_c;
  logic       out_valid_r, out_inv_r;
  year_t      out_year_r;
  month_t     out_month_r;
  day_t       out_day_r;
  hour_t      out_hour_r;
  minute_t    out_minute_r;
  second_t    out_second_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= LEAP_OFS_RESET;
    end else if (cfg_wr_en) begin
      leap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // stage 1: day of week, seconds of day, shifted day count
  always_comb begin
    dow_c = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (in_ch.time_of_week >= 20'(k * 86400)) begin
        dow_c = 3'(k);
      end
    end
    day_base = 20'(dow_c) * 20'(SEC_PER_DAY);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv1_r <= (in_ch.time_of_week >= SEC_PER_WEEK);
      sod1_r <= 17'(in_ch.time_of_week - day_base);
      t1_r   <= ({in_ch.week_num, 3'b000} - {3'b000, in_ch.week_num})
                + {12'd0, dow_c} + EPOCH_SHIFT;
    end
  end

  // stage 2: leap second subtraction with day borrow
  assign brw_c = (sod1_r < {11'd0, leap_r});

  always_ff @(posedge clk) begin
    if (en) begin
      inv2_r <= inv1_r;
      brw2_r <= brw_c;
      if (brw_c) begin
        sod2_r <= 17'({1'b0, sod1_r} + {1'b0, SEC_PER_DAY} - {12'd0, leap_r});
      end else begin
        sod2_r <= sod1_r - {11'd0, leap_r};
      end
    end
  end

  // stage 3: hour product
  always_ff @(posedge clk) begin
    if (en) begin
      inv3_r   <= inv2_r;
      hprod3_r <= 26'(sod2_r[16:4]) * 26'(HOUR_RECIP);
      sod3_r   <= sod2_r;
    end
  end

  // stage 4: hour and seconds of hour
  assign hour_c = hprod3_r[HOUR_SHIFT+4:HOUR_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      inv4_r  <= inv3_r;
      hour4_r <= hour_c;
      rem4_r  <= 12'(sod3_r - 17'(hour_c) * 17'(SEC_PER_HOUR));
    end
  end

  // stage 5: minute product
  always_ff @(posedge clk) begin
    if (en) begin
      inv5_r   <= inv4_r;
      hour5_r  <= hour4_r;
      rem5_r   <= rem4_r;
      mprod5_r <= 21'(rem4_r[11:2]) * 21'(MIN_RECIP);
    end
  end

  gtu_date u_date (
    .clk      (clk),
    .en       (en),
    .t_i      (t1_r),
    .borrow_i (brw2_r),
    .date_o   (date_c)
  );

  // output stage
  assign minute_c = mprod5_r[MIN_SHIFT+5:MIN_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      out_inv_r <= inv5_r;
      if (inv5_r) begin
        out_year_r   <= '0;
        out_month_r  <= '0;
        out_day_r    <= '0;
        out_hour_r   <= '0;
        out_minute_r <= '0;
        out_second_r <= '0;
      end else begin
        out_year_r   <= date_c.year;
        out_month_r  <= date_c.month;
        out_day_r    <= date_c.day;
        out_hour_r   <= hour5_r;
        out_minute_r <= minute_c;
        out_second_r <= 6'(rem5_r - 12'(minute_c) * 12'(SEC_PER_MIN));
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.year          = out_year_r;
  assign out_ch.month         = out_month_r;
  assign out_ch.day           = out_day_r;
  assign out_ch.hour          = out_hour_r;
  assign out_ch.minute        = out_minute_r;
  assign out_ch.second        = out_second_r;
  assign out_ch.input_invalid = out_inv_r;

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inv_r) |->
      (out_month_r >= JANUARY) && (out_month_r <= DECEMBER) && (out_day_r != 5'd0) &&
      (out_hour_r < 5'd24) && (out_minute_r < 6'd60) && (out_second_r < 6'd60))
    else $error("calendar field out of range");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |->
      (out_year_r == '0) && (out_month_r == '0) && (out_day_r == '0) &&
      (out_hour_r == '0) && (out_minute_r == '0) && (out_second_r == '0))
    else $error("invalid item carries nonzero fields");

  a_feb29_leap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inv_r && (out_month_r == 4'd2) && (out_day_r == 5'd29)) |->
      (out_year_r[1:0] == 2'b00))
    else $error("29 February in a common year");

endmodule
